### design/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg: shared types and constants of the track slope derivative unit
// Word formats, field model limits and pipeline sizing.
// ----------------------------------------------------------------------------
package tsd_pkg;

	// input word, fields in order, first field in the top bits
	typedef struct packed {
		logic signed [15:0] pos_z;
		logic signed [31:0] slope_x;
		logic signed [31:0] slope_y;
		logic signed [31:0] charge_over_momentum;
		logic signed [15:0] field_x;
		logic signed [15:0] field_y;
		logic signed [15:0] field_z;
	} in_t;

	// result word
	typedef struct packed {
		logic signed [63:0] curv_x;
		logic signed [63:0] curv_y;
	} out_t;

	// classified word: clamped slopes and resolved field
	typedef struct packed {
		logic signed [30:0] x;
		logic signed [30:0] y;
		logic signed [31:0] qp;
		logic signed [15:0] bx;
		logic signed [15:0] by;
		logic signed [15:0] bz;
	} item_t;

	// slope clamp, +-10000 in Q.16
	localparam logic signed [31:0] SLOPE_LIMIT = 32'sd655360000;
	// 0.00299792458 in Q.32
	localparam logic signed [24:0] KAPPA_Q32 = 25'sd12875988;
	// default field model, z in Q.4, field in Q.12
	localparam logic signed [15:0] Z_BZ_OFF = 16'sd3200;
	localparam logic signed [15:0] Z_BY_LO = 16'sd5600;
	localparam logic signed [15:0] Z_BY_HI = 16'sd7200;
	localparam logic signed [15:0] BZ_DEFAULT = 16'sd8192;
	localparam logic signed [15:0] BY_DEFAULT = 16'sd2048;

	// configuration map
	localparam int CFG_ADDR_W = 3;
	localparam logic REG_USE_FIELD_INPUT = 1'b0;

	// queue and pipeline sizing
	localparam int QUEUE_DEPTH = 4;
	localparam int SQRT_STEPS = 30;
	localparam int BACK_STAGES = 5 + SQRT_STEPS + 2 + 5;

endpackage

### design/tsd_front.sv
// ----------------------------------------------------------------------------
// tsd_front: input stage
// Takes input words, clamps the slopes and resolves the field source.
// ----------------------------------------------------------------------------
module tsd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          use_field_input,
	input  logic          in_valid,
	output logic          in_ready,
	input  tsd_pkg::in_t  in_data,
	output logic          push_valid,
	input  logic          push_ready,
	output tsd_pkg::item_t push_data
);
	import tsd_pkg::*;

	logic  fv_q;
	item_t item_q;
	item_t item_c;

	// clamp slopes, pick field from word or from the default model by z
	always_comb begin
		item_c.qp = in_data.charge_over_momentum;
		if (in_data.slope_x > SLOPE_LIMIT) begin
			item_c.x = SLOPE_LIMIT[30:0];
		end else if (in_data.slope_x < -SLOPE_LIMIT) begin
			item_c.x = 31'(-SLOPE_LIMIT);
		end else begin
			item_c.x = in_data.slope_x[30:0];
		end
		if (in_data.slope_y > SLOPE_LIMIT) begin
			item_c.y = SLOPE_LIMIT[30:0];
		end else if (in_data.slope_y < -SLOPE_LIMIT) begin
			item_c.y = 31'(-SLOPE_LIMIT);
		end else begin
			item_c.y = in_data.slope_y[30:0];
		end
		if (use_field_input) begin
			item_c.bx = in_data.field_x;
			item_c.by = in_data.field_y;
			item_c.bz = in_data.field_z;
		end else begin
			item_c.bx = '0;
			item_c.bz = (in_data.pos_z > Z_BZ_OFF) ? '0 : BZ_DEFAULT;
			item_c.by = (in_data.pos_z > Z_BY_LO && in_data.pos_z < Z_BY_HI) ?
				BY_DEFAULT : '0;
		end
	end

	assign in_ready   = !fv_q || push_ready;
	assign push_valid = fv_q;
	assign push_data  = item_q;

	// holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= 1'b0;
		end else if (in_ready) begin
			fv_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= item_c;
		end
	end

endmodule

### design/tsd_queue.sv
// ----------------------------------------------------------------------------
// tsd_queue: short word queue
// Decouples the input stage from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module tsd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  tsd_pkg::item_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output tsd_pkg::item_t pop_data
);
	import tsd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = store_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### design/tsd_back.sv
// ----------------------------------------------------------------------------
// tsd_back: arithmetic pipeline
// Squares, field brackets, pipelined square root, scale and final product.
// ----------------------------------------------------------------------------
module tsd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  tsd_pkg::item_t pop_data,
	output logic           out_valid,
	input  logic           out_ready,
	output tsd_pkg::out_t  out_data
);
	import tsd_pkg::*;

	typedef struct packed {
		logic [32:0]        rem;
		logic [29:0]        root;
		logic [59:0]        rad;
		logic signed [31:0] k;
		logic signed [49:0] br0;
		logic signed [49:0] br1;
	} sq_t;

	logic en;
	logic [BACK_STAGES-1:0] vld_q;

	assign en        = !vld_q[BACK_STAGES-1] || out_ready;
	assign pop_ready = en;
	assign out_valid = vld_q[BACK_STAGES-1];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[BACK_STAGES-2:0], pop_valid};
		end
	end

	// stage 1: squares, cross product, raw scale
	logic signed [61:0] x2_c, y2_c, xy_c;
	logic signed [55:0] kraw_c;
	logic [58:0]        x2_s1, y2_s1;
	logic signed [61:0] xy_s1;
	logic signed [55:0] kraw_s1;
	item_t              it_s1;

	assign x2_c   = pop_data.x * pop_data.x;
	assign y2_c   = pop_data.y * pop_data.y;
	assign xy_c   = pop_data.x * pop_data.y;
	assign kraw_c = pop_data.qp * KAPPA_Q32;

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s1   <= x2_c[58:0];
			y2_s1   <= y2_c[58:0];
			xy_s1   <= xy_c;
			kraw_s1 <= kraw_c;
			it_s1   <= pop_data;
		end
	end

	// stage 2: round to Q.16, radicand, scale rounded to Q.32
	logic signed [61:0] xy_r;
	logic [59:0]        ox_r, oy_r, rad_c;
	logic signed [55:0] k_r;
	logic signed [45:0] xy16_s2;
	logic [43:0]        ox16_s2, oy16_s2;
	logic [59:0]        rad_s2;
	logic signed [31:0] k_s2;
	item_t              it_s2;

	always_comb begin
		xy_r  = xy_s1 + 62'sd32768 - {61'd0, xy_s1[61]};
		ox_r  = 60'h1_0000_0000 + {1'b0, x2_s1} + 60'd32768;
		oy_r  = 60'h1_0000_0000 + {1'b0, y2_s1} + 60'd32768;
		rad_c = 60'h1_0000_0000 + {1'b0, x2_s1} + {1'b0, y2_s1};
		k_r   = kraw_s1 + 56'sd8388608 - {55'd0, kraw_s1[55]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xy16_s2 <= xy_r[61:16];
			ox16_s2 <= ox_r[59:16];
			oy16_s2 <= oy_r[59:16];
			rad_s2  <= rad_c;
			k_s2    <= k_r[55:24];
			it_s2   <= it_s1;
		end
	end

	// stage 3: field products
	logic signed [61:0] p0_c, p1_c, p2_c, p3_c, p4_c, p5_c;
	logic signed [61:0] p0_s3, p1_s3, p2_s3, p3_s3, p4_s3, p5_s3;
	logic [59:0]        rad_s3;
	logic signed [31:0] k_s3;

	assign p0_c = xy16_s2 * it_s2.bx;
	assign p1_c = $signed({1'b0, ox16_s2}) * it_s2.by;
	assign p2_c = it_s2.y * it_s2.bz;
	assign p3_c = xy16_s2 * it_s2.by;
	assign p4_c = $signed({1'b0, oy16_s2}) * it_s2.bx;
	assign p5_c = it_s2.x * it_s2.bz;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s3  <= p0_c;
			p1_s3  <= p1_c;
			p2_s3  <= p2_c;
			p3_s3  <= p3_c;
			p4_s3  <= p4_c;
			p5_s3  <= p5_c;
			rad_s3 <= rad_s2;
			k_s3   <= k_s2;
		end
	end

	// stage 4: bracket sums in Q.28
	logic signed [61:0] t0_s4, t1_s4;
	logic [59:0]        rad_s4;
	logic signed [31:0] k_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			t0_s4  <= p0_s3 - p1_s3 + p2_s3;
			t1_s4  <= p4_s3 - p3_s3 - p5_s3;
			rad_s4 <= rad_s3;
			k_s4   <= k_s3;
		end
	end

	// stage 5: brackets rounded to Q.16
	logic signed [61:0] t0_r, t1_r;
	sq_t                sq_s5;

	always_comb begin
		t0_r = t0_s4 + 62'sd2048 - {61'd0, t0_s4[61]};
		t1_r = t1_s4 + 62'sd2048 - {61'd0, t1_s4[61]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s5.rem  <= '0;
			sq_s5.root <= '0;
			sq_s5.rad  <= rad_s4;
			sq_s5.k    <= k_s4;
			sq_s5.br0  <= t0_r[61:12];
			sq_s5.br1  <= t1_r[61:12];
		end
	end

	// square root: one result bit per stage, top digit pair first
	sq_t sq_in  [SQRT_STEPS];
	sq_t sq_nx  [SQRT_STEPS];
	sq_t sq_s   [SQRT_STEPS];

	assign sq_in[0] = sq_s5;

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam int BIT = 2 * (SQRT_STEPS - 1 - j);
		logic [32:0] rem_in;
		logic [32:0] trial;
		sq_t         nx;

		if (j > 0) begin : g_link
			assign sq_in[j] = sq_s[j-1];
		end

		always_comb begin
			rem_in = {sq_in[j].rem[30:0], sq_in[j].rad[BIT+1 -: 2]};
			trial  = {1'b0, sq_in[j].root, 2'b01};
			nx     = sq_in[j];
			if (rem_in >= trial) begin
				nx.rem  = rem_in - trial;
				nx.root = {sq_in[j].root[28:0], 1'b1};
			end else begin
				nx.rem  = rem_in;
				nx.root = {sq_in[j].root[28:0], 1'b0};
			end
		end

		assign sq_nx[j] = nx;
	end

	// square root stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s <= sq_nx;
		end
	end

	// scale: f = k * s, then rounded to Q.32
	logic signed [62:0] kp_c;
	logic signed [62:0] kp_s6;
	logic signed [62:0] kp_r;
	logic signed [49:0] br0_s6, br1_s6, br0_s7, br1_s7;
	logic signed [46:0] f_s7;

	assign kp_c = sq_s[SQRT_STEPS-1].k * $signed({1'b0, sq_s[SQRT_STEPS-1].root});
	assign kp_r = kp_s6 + 63'sd32768 - {62'd0, kp_s6[62]};

	always_ff @(posedge clk) begin
		if (en) begin
			kp_s6  <= kp_c;
			br0_s6 <= sq_s[SQRT_STEPS-1].br0;
			br1_s6 <= sq_s[SQRT_STEPS-1].br1;
			f_s7   <= kp_r[62:16];
			br0_s7 <= br0_s6;
			br1_s7 <= br1_s6;
		end
	end

	// product stage 1: sign and magnitude
	logic [45:0] af_m1;
	logic [48:0] ab0_m1, ab1_m1;
	logic        neg0_m1, neg1_m1;
	logic [46:0] f_abs;
	logic [49:0] b0_abs, b1_abs;

	always_comb begin
		f_abs  = f_s7[46] ? 47'(-f_s7) : f_s7;
		b0_abs = br0_s7[49] ? 50'(-br0_s7) : br0_s7;
		b1_abs = br1_s7[49] ? 50'(-br1_s7) : br1_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			af_m1   <= f_abs[45:0];
			ab0_m1  <= b0_abs[48:0];
			ab1_m1  <= b1_abs[48:0];
			neg0_m1 <= f_s7[46] ^ br0_s7[49];
			neg1_m1 <= f_s7[46] ^ br1_s7[49];
		end
	end

	// product stage 2: partial products of 24/22 by 25/24 bit limbs
	logic [48:0] q00_m2, r00_m2;
	logic [47:0] q01_m2, r01_m2;
	logic [46:0] q10_m2, r10_m2;
	logic [45:0] q11_m2, r11_m2;
	logic        neg0_m2, neg1_m2;

	always_ff @(posedge clk) begin
		if (en) begin
			q00_m2  <= af_m1[23:0] * ab0_m1[24:0];
			q01_m2  <= af_m1[23:0] * ab0_m1[48:25];
			q10_m2  <= af_m1[45:24] * ab0_m1[24:0];
			q11_m2  <= af_m1[45:24] * ab0_m1[48:25];
			r00_m2  <= af_m1[23:0] * ab1_m1[24:0];
			r01_m2  <= af_m1[23:0] * ab1_m1[48:25];
			r10_m2  <= af_m1[45:24] * ab1_m1[24:0];
			r11_m2  <= af_m1[45:24] * ab1_m1[48:25];
			neg0_m2 <= neg0_m1;
			neg1_m2 <= neg1_m1;
		end
	end

	// product stage 3: sum the partials
	logic [95:0] m0_m3, m1_m3;
	logic        neg0_m3, neg1_m3;

	always_ff @(posedge clk) begin
		if (en) begin
			m0_m3 <= ({50'd0, q11_m2} << 49) + ({49'd0, q10_m2} << 24)
				+ ({48'd0, q01_m2} << 25) + {47'd0, q00_m2};
			m1_m3 <= ({50'd0, r11_m2} << 49) + ({49'd0, r10_m2} << 24)
				+ ({48'd0, r01_m2} << 25) + {47'd0, r00_m2};
			neg0_m3 <= neg0_m2;
			neg1_m3 <= neg1_m2;
		end
	end

	// product stage 4: round to Q.16
	logic [96:0] s0_r, s1_r;
	logic [64:0] rr0_m4, rr1_m4;
	logic        neg0_m4, neg1_m4;

	assign s0_r = {1'b0, m0_m3} + 97'h8000_0000;
	assign s1_r = {1'b0, m1_m3} + 97'h8000_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			rr0_m4  <= s0_r[96:32];
			rr1_m4  <= s1_r[96:32];
			neg0_m4 <= neg0_m3;
			neg1_m4 <= neg1_m3;
		end
	end

	// product stage 5: saturate and restore sign
	logic [64:0] lim0, lim1, mag0, mag1;
	out_t        res_m5;

	always_comb begin
		lim0 = neg0_m4 ? 65'h0_8000_0000_0000_0000 : 65'h0_7FFF_FFFF_FFFF_FFFF;
		lim1 = neg1_m4 ? 65'h0_8000_0000_0000_0000 : 65'h0_7FFF_FFFF_FFFF_FFFF;
		mag0 = (rr0_m4 > lim0) ? lim0 : rr0_m4;
		mag1 = (rr1_m4 > lim1) ? lim1 : rr1_m4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_m5.curv_x <= neg0_m4 ? -mag0[63:0] : mag0[63:0];
			res_m5.curv_y <= neg1_m4 ? -mag1[63:0] : mag1[63:0];
		end
	end

	assign out_data = res_m5;

endmodule

### design/track_slope_derivative_unit.sv
// Path: input holding register, word queue, then the back pipeline to the result register.
// Throughput: one word per cycle while results are taken; the square root is a 30-stage pipeline.
// The result register stalls the whole back pipeline; a 4-word queue lets
// the input side keep accepting meanwhile.
// Reset: arst_n clears all valid state and the mode register (default field).
// ----------------------------------------------------------------------------
// track_slope_derivative_unit: top level
// Track curvature in z from slopes, charge over momentum and field.
// ----------------------------------------------------------------------------
module track_slope_derivative_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tsd_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  tsd_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output tsd_pkg::out_t                  out_data
);
	import tsd_pkg::*;

	logic  use_field_q;
	logic  push_valid, push_ready, pop_valid, pop_ready;
	item_t push_data, pop_data;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_USE_FIELD_INPUT) ? {31'd0, use_field_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_field_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == REG_USE_FIELD_INPUT) begin
			use_field_q <= pwdata[0];
		end
	end

	tsd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.use_field_input (use_field_q),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.push_valid      (push_valid),
		.push_ready      (push_ready),
		.push_data       (push_data)
	);

	tsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### design/tsd_checker.sv
// ----------------------------------------------------------------------------
// tsd_checker: port-level checks
// Result handshake and configuration readback, bound to the top level.
// ----------------------------------------------------------------------------
module tsd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           psel,
	input logic                           penable,
	input logic                           pwrite,
	input logic [tsd_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [31:0]                    pwdata,
	input logic [31:0]                    prdata,
	input logic                           pready,
	input logic                           out_valid,
	input logic                           out_ready,
	input tsd_pkg::out_t                  out_data
);
	import tsd_pkg::*;

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// and keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result word changed while stalled");

	// mode register reads back what was written
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[2] == REG_USE_FIELD_INPUT)
		##1 (paddr[2] == REG_USE_FIELD_INPUT) |-> prdata[0] == $past(pwdata[0]))
		else $error("mode register readback mismatch");

	// only the mode bit is implemented
	a_cfg_upper: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:1] == '0)
		else $error("unimplemented register bits read non-zero");

endmodule

bind track_slope_derivative_unit tsd_checker u_tsd_checker (.*);

### tb/sv/tb_track_slope_derivative_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_track_slope_derivative_unit: self-checking bench for the curvature unit
// Drives slope, charge and field words through the valid/ready channel, works
// out the expected curvature per word in a bit-exact predictor and compares
// each result word in order. Both field sources are exercised over APB.
// ----------------------------------------------------------------------------
module tb_track_slope_derivative_unit;
	import tsd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;

	track_slope_derivative_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	localparam int DRAIN_CYCLES = 80;

	// predictor's copy of the mode register
	bit    field_from_word;
	out_t  curv_expected[$];
	int    n_errors;
	bit    rx_hold;       // long receiver hold-off request
	bit    rx_no_idle;    // stretch with no receiver idling
	bit    tx_no_idle;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// round to nearest, ties away from zero, arithmetic shift right
	function automatic longint round_shift(longint v, int s);
		longint unsigned m;
		longint unsigned r;
		m = (v < 0) ? -v : v;
		r = (m + (64'd1 << (s - 1))) >> s;
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint clamp_slope(logic signed [31:0] v);
		longint w;
		w = v;
		if (w > 655360000) return 655360000;
		if (w < -655360000) return -655360000;
		return w;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// round(a*b / 2^32) saturated to 64-bit signed
	function automatic logic signed [63:0] mul_q32_sat(longint a, longint b);
		logic signed [127:0] p;
		logic signed [127:0] r;
		p = 128'(signed'(a)) * 128'(signed'(b));
		if (p < 0) r = -((-p + (128'sd1 <<< 31)) >>> 32);
		else       r = (p + (128'sd1 <<< 31)) >>> 32;
		if (r > 128'sh7FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
		if (r < -128'sh8000000000000000) return 64'sh8000000000000000;
		return r[63:0];
	endfunction

	function automatic out_t predict_curvature(in_t w);
		longint z, x, y, qp, bx, by, bz;
		longint x2, y2, xy16, ox16, oy16, t0, t1, br0, br1, s, k, f;
		out_t o;
		z = w.pos_z;
		x = clamp_slope(w.slope_x);
		y = clamp_slope(w.slope_y);
		qp = w.charge_over_momentum;
		if (field_from_word) begin
			bx = w.field_x; by = w.field_y; bz = w.field_z;
		end else begin
			bx = 0;
			bz = (z > Z_BZ_OFF) ? 0 : BZ_DEFAULT;
			by = (z > Z_BY_LO && z < Z_BY_HI) ? BY_DEFAULT : 0;
		end
		x2 = x * x;
		y2 = y * y;
		xy16 = round_shift(x * y, 16);
		ox16 = round_shift((64'sd1 <<< 32) + x2, 16);
		oy16 = round_shift((64'sd1 <<< 32) + y2, 16);
		t0 = xy16 * bx - ox16 * by + y * bz;
		t1 = -(xy16 * by) + oy16 * bx - x * bz;
		br0 = round_shift(t0, 12);
		br1 = round_shift(t1, 12);
		s = floor_sqrt((64'd1 << 32) + x2 + y2);
		k = round_shift(qp * KAPPA_Q32, 24);
		f = round_shift(k * s, 16);
		o.curv_x = mul_q32_sat(f, br0);
		o.curv_y = mul_q32_sat(f, br1);
		return o;
	endfunction

	// APB write, setup then access phase
	task automatic apb_write(logic [CFG_ADDR_W-1:0] a, logic [31:0] d);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (a == 4 * REG_USE_FIELD_INPUT) field_from_word = d[0];
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// stop offering, wait until every expected word has arrived, plus drain time
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (curv_expected.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_mode(bit m);
		wait_drained();
		apb_write(CFG_ADDR_W'(4 * REG_USE_FIELD_INPUT), {$urandom} & ~32'h1 | m);
	endtask

	// send one word; called at a falling edge, valid is dropped only for a gap
	task automatic send_word(in_t w);
		int gap;
		gap = tx_no_idle ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		curv_expected.push_back(predict_curvature(w));
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_slope();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'(655360000 + $urandom_range(0, 5))
				: 32'(-655360000 - $urandom_range(0, 5));
			2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
		endcase
	endfunction

	function automatic in_t rand_word();
		in_t w;
		w.pos_z = $urandom_range(0, 3) == 0 ? 16'($urandom)
			: 16'($urandom_range(3000, 7400));
		w.slope_x = rand_slope();
		w.slope_y = rand_slope();
		w.charge_over_momentum = $urandom_range(0, 3) == 0 ? $urandom
			: 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
		w.field_x = 16'($urandom);
		w.field_y = 16'($urandom);
		w.field_z = 16'($urandom);
		return w;
	endfunction

	function automatic in_t make_word(logic [15:0] z, logic [31:0] sx, logic [31:0] sy,
			logic [31:0] qp, logic [15:0] bx, logic [15:0] by, logic [15:0] bz);
		in_t w;
		w.pos_z = z; w.slope_x = sx; w.slope_y = sy; w.charge_over_momentum = qp;
		w.field_x = bx; w.field_y = by; w.field_z = bz;
		return w;
	endfunction

	// default field model boundaries in z
	task automatic test_default_field();
		logic [15:0] zs[10];
		zs = '{16'h8000, 16'd0, 16'd3200, 16'd3201, 16'd5600, 16'd5601,
			16'd7199, 16'd7200, 16'h7FFF, 16'hFFFF};
		set_mode(1'b0);
		foreach (zs[i])
			send_word(make_word(zs[i], 32'sd65536, -32'sd131072, 32'sd16777216,
				16'h7FFF, 16'h8000, 16'h1234));
	endtask

	// field from word: field extremes, slope clamping, saturation
	task automatic test_field_input();
		set_mode(1'b1);
		send_word(make_word(16'h1234, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			16'h7FFF, 16'h7FFF, 16'h7FFF));
		send_word(make_word(16'h0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			16'h8000, 16'h8000, 16'h8000));
		send_word(make_word(16'h0, 32'sd655360001, -32'sd655360001, 32'sd1,
			16'h8000, 16'h7FFF, 16'h0));
		send_word(make_word(16'h0, 32'sd655360000, -32'sd655360000, -32'sd1,
			16'h1000, 16'h0, 16'hF000));
		send_word(make_word(16'h0, 32'h0, 32'h0, 32'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		send_word(make_word(16'h0, 32'h0, 32'h0, 32'sd16777216, 16'h0, 16'h0, 16'h1000));
		send_word(make_word(16'hFFFF, 32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF,
			16'hFFFF, 16'h1, 16'hFFFF));
		send_word(make_word(16'h5555, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
			16'hAAAA, 16'h5555, 16'hAAAA));
	endtask

	// random words, switching field source between phases
	task automatic test_random(int n_words);
		for (int i = 0; i < n_words; i++) begin
			if (i % 200 == 0) set_mode(1'($urandom_range(0, 1)));
			tx_no_idle = (i % 300) >= 250;
			send_word(rand_word());
		end
		tx_no_idle = 1'b0;
	endtask

	// receiver stalls long while words keep coming, then sender waits drained
	task automatic test_backpressure();
		rx_hold = 1'b1;
		tx_no_idle = 1'b1;
		for (int i = 0; i < 80; i++) send_word(rand_word());
		tx_no_idle = 1'b0;
		wait_drained();
		for (int i = 0; i < 10; i++) send_word(rand_word());
	endtask

	// result side: ready idling and the hold-off
	initial begin
		int hold;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				out_ready <= 1'b0;
				repeat (150) @(negedge clk);
				rx_hold = 1'b0;
			end
			hold = rx_no_idle ? 0 : $urandom_range(0, 18);
			if (hold == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
				@(negedge clk);
				out_ready <= 1'b1;
			end
			@(posedge clk);
			while (!(out_valid && out_ready)) @(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (curv_expected.size() == 0) begin
				$display("%0t unexpected word, actual x=%0d y=%0d", $time,
					out_data.curv_x, out_data.curv_y);
				n_errors++;
			end else begin
				e = curv_expected.pop_front();
				if (out_data.curv_x !== e.curv_x) begin
					$display("%0t curv_x expected %0d actual %0d", $time,
						e.curv_x, out_data.curv_x);
					n_errors++;
				end
				if (out_data.curv_y !== e.curv_y) begin
					$display("%0t curv_y expected %0d actual %0d", $time,
						e.curv_y, out_data.curv_y);
					n_errors++;
				end
			end
		end
	end

	// sequence
	initial begin
		n_errors = 0;
		field_from_word = 1'b0;
		rx_hold = 1'b0;
		rx_no_idle = 1'b0;
		tx_no_idle = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_default_field();
		test_field_input();
		test_backpressure();
		test_random(600);
		rx_no_idle = 1'b1;
		test_random(600);
		rx_no_idle = 1'b0;
		wait_drained();
		if (n_errors == 0 && curv_expected.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### files.f
design/tsd_pkg.sv
design/tsd_front.sv
design/tsd_queue.sv
design/tsd_back.sv
design/track_slope_derivative_unit.sv
design/tsd_checker.sv
tb/sv/tb_track_slope_derivative_unit.sv
